@@ hw/rtl/jpeg_idct_8x8_aan_macros.svh @@
// Assertion macros used by the checker file.
`ifndef JPEG_IDCT_8X8_AAN_MACROS_SVH
`define JPEG_IDCT_8X8_AAN_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define JIDCT_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent follows an antecedent in the next cycle.
`define JIDCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Check that a consequent holds in the same cycle as an antecedent.
`define JIDCT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ hw/rtl/jidct_pkg.sv @@
package jidct_pkg;

    localparam int COEF_W   = 12;
    localparam int SAMPLE_W = 8;
    localparam int DATA_W   = 48;
    localparam int TR_W     = 32;
    localparam int SCALE_W  = 16;
    localparam int K_W      = 18;

    localparam longint unsigned BILLION = 64'd1000000000;

    localparam longint unsigned AAN_PPB [8] = '{
        64'd1000000000, 64'd1387039845, 64'd1306562965, 64'd1175875602,
        64'd1000000000, 64'd785694958,  64'd541196100,  64'd275899379
    };

    localparam longint unsigned PPB_SQRT2 = 64'd1414213562;
    localparam longint unsigned PPB_ROT   = 64'd1847759065;
    localparam longint unsigned PPB_EVEN  = 64'd1082392200;
    localparam longint unsigned PPB_ODD   = 64'd2613125930;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [SCALE_W-1:0] t_scale_tab [64];

    // Block token: one complete block of coefficients sitting in a bank
    typedef struct packed {
        logic valid;
        logic bank;
    } t_tok;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOAD,
        ST_CBF,
        ST_CSTORE,
        ST_RLOAD,
        ST_RBF,
        ST_ROUT
    } t_state;

    // Constant in fixed point, rounded to nearest with ties up
    function automatic logic [K_W-1:0] qconst(longint unsigned ppb, int fb);
        longint unsigned v;
        v = ((ppb << fb) + BILLION / 2) / BILLION;
        return v[K_W-1:0];
    endfunction

    // AAN scale table, row factor times column factor over eight
    function automatic t_scale_tab build_scale(int fb);
        t_scale_tab tab;
        longint unsigned q;
        longint unsigned e;
        for (int i = 0; i < 64; i++) begin
            q = (AAN_PPB[(i >> 3) & 7] * AAN_PPB[i & 7] + BILLION / 2) / BILLION;
            e = ((q << fb) + 4 * BILLION) / (8 * BILLION);
            tab[i] = e[SCALE_W-1:0];
        end
        return tab;
    endfunction

    // Multiply by a constant, round to nearest with ties up
    function automatic t_word mul_k(t_word a, logic [K_W-1:0] k, int fb);
        logic signed [DATA_W+K_W:0] p;
        p = a * $signed({1'b0, k});
        p = p + $signed((DATA_W + K_W + 1)'(1) << (fb - 1));
        return t_word'(p >>> fb);
    endfunction

endpackage

@@ hw/rtl/jpeg_idct_8x8_aan.sv @@
// Channel   | Handshake        | Payload
// ----------+------------------+-------------------------------------------
// input     | push / full      | i_coefficient (12b signed, row-major)
// result    | pop / empty      | o_sample (8b), o_last_of_block (1b)
//
// A block of 64 coefficients loads at one per cycle, while full is low, into one of
// two banks. The back end takes the block, then runs eight column and eight row
// passes; each pass reads eight operands, runs the butterfly, and then makes eight
// stores (column passes) or result pushes (row passes).
// full rises when both banks hold blocks whose column passes are not done.
// Synchronous active-low reset clears control; a stalled pop holds the row output step.
module jpeg_idct_8x8_aan #(
    parameter int FRACTION_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [jidct_pkg::COEF_W-1:0]    i_coefficient,
    output logic                            empty,
    input  logic                            pop,
    output logic [jidct_pkg::SAMPLE_W-1:0]  o_sample,
    output logic                            o_last_of_block
);
    import jidct_pkg::*;

    logic              w_cwe;
    logic [6:0]        w_cwaddr;
    logic [COEF_W-1:0] w_cwdata;
    logic              w_cre;
    logic [6:0]        w_craddr;
    logic [COEF_W-1:0] w_crdata;
    logic              w_twe;
    logic [5:0]        w_twaddr;
    logic [TR_W-1:0]   w_twdata;
    logic              w_tre;
    logic [5:0]        w_traddr;
    logic [TR_W-1:0]   w_trdata;
    t_tok              w_tok_in;
    t_tok              w_tok_out;
    logic              w_tok_pop;
    logic              w_release;
    logic              w_bf_start;
    logic              w_bf_done;
    t_word             w_bf_x [8];
    t_word             w_bf_y [8];

    jidct_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_coefficient (i_coefficient),
        .i_release     (w_release),
        .o_we          (w_cwe),
        .o_waddr       (w_cwaddr),
        .o_wdata       (w_cwdata),
        .o_tok         (w_tok_in)
    );

    jidct_ram #(.WIDTH(COEF_W), .DEPTH(128)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_cwe),
        .i_waddr (w_cwaddr),
        .i_wdata (w_cwdata),
        .i_re    (w_cre),
        .i_raddr (w_craddr),
        .o_rdata (w_crdata)
    );

    jidct_tokq u_tokq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (w_tok_in),
        .i_pop   (w_tok_pop),
        .o_tok   (w_tok_out)
    );

    jidct_ram #(.WIDTH(TR_W), .DEPTH(64)) u_tr_ram (
        .i_clk   (i_clk),
        .i_we    (w_twe),
        .i_waddr (w_twaddr),
        .i_wdata (w_twdata),
        .i_re    (w_tre),
        .i_raddr (w_traddr),
        .o_rdata (w_trdata)
    );

    jidct_bfly #(.FRACTION_BITS(FRACTION_BITS)) u_bfly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bf_start),
        .i_x     (w_bf_x),
        .o_done  (w_bf_done),
        .o_y     (w_bf_y)
    );

    jidct_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tok           (w_tok_out),
        .o_tok_pop       (w_tok_pop),
        .o_release       (w_release),
        .o_coef_re       (w_cre),
        .o_coef_raddr    (w_craddr),
        .i_coef_rdata    (w_crdata),
        .o_tr_we         (w_twe),
        .o_tr_waddr      (w_twaddr),
        .o_tr_wdata      (w_twdata),
        .o_tr_re         (w_tre),
        .o_tr_raddr      (w_traddr),
        .i_tr_rdata      (w_trdata),
        .o_bf_start      (w_bf_start),
        .o_bf_x          (w_bf_x),
        .i_bf_done       (w_bf_done),
        .i_bf_y          (w_bf_y),
        .empty           (empty),
        .pop             (pop),
        .o_sample        (o_sample),
        .o_last_of_block (o_last_of_block)
    );

endmodule

@@ hw/rtl/jidct_ram.sv @@
module jidct_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ hw/rtl/jidct_front.sv @@
module jidct_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [jidct_pkg::COEF_W-1:0]  i_coefficient,
    input  logic                          i_release,
    output logic                          o_we,
    output logic [6:0]                    o_waddr,
    output logic [jidct_pkg::COEF_W-1:0]  o_wdata,
    output jidct_pkg::t_tok               o_tok
);
    import jidct_pkg::*;

    logic [5:0] r_count;
    logic       r_bank;
    logic [1:0] r_busy;
    logic       w_accept;
    logic       w_done;

    assign full     = (r_busy == 2'd2);
    assign w_accept = push && !full;
    assign w_done   = w_accept && (r_count == 6'd63);

    assign o_we    = w_accept;
    assign o_waddr = {r_bank, r_count};
    assign o_wdata = i_coefficient;

    assign o_tok.valid = w_done;
    assign o_tok.bank  = r_bank;

    // Advance load position, flip bank per block, track banks in use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bank  <= 1'b0;
            r_busy  <= '0;
        end else begin
            if (w_accept) begin
                r_count <= r_count + 6'd1;
            end
            if (w_done) begin
                r_bank <= !r_bank;
            end
            if (w_done && !i_release) begin
                r_busy <= r_busy + 2'd1;
            end else if (!w_done && i_release) begin
                r_busy <= r_busy - 2'd1;
            end
        end
    end

endmodule

@@ hw/rtl/jidct_tokq.sv @@
module jidct_tokq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  jidct_pkg::t_tok i_tok,
    input  logic            i_pop,
    output jidct_pkg::t_tok o_tok
);
    import jidct_pkg::*;

    logic [1:0] r_q;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign w_pop       = i_pop && (r_cnt != 2'd0);
    assign o_tok.valid = (r_cnt != 2'd0);
    assign o_tok.bank  = r_q[0];

    // Two-entry queue of block tokens, oldest in slot zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_tok.valid && !w_pop) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (!i_tok.valid && w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.valid && w_pop) begin
            if (r_cnt == 2'd1) begin
                r_q[0] <= i_tok.bank;
            end else begin
                r_q[0] <= r_q[1];
                r_q[1] <= i_tok.bank;
            end
        end else if (w_pop) begin
            r_q[0] <= r_q[1];
        end else if (i_tok.valid) begin
            r_q[r_cnt[0]] <= i_tok.bank;
        end
    end

endmodule

@@ hw/rtl/jidct_bfly.sv @@
module jidct_bfly #(
    parameter int FRACTION_BITS = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  jidct_pkg::t_word i_x [8],
    output logic             o_done,
    output jidct_pkg::t_word o_y [8]
);
    import jidct_pkg::*;

    localparam logic [K_W-1:0] K_SQRT2 = qconst(PPB_SQRT2, FRACTION_BITS);
    localparam logic [K_W-1:0] K_ROT   = qconst(PPB_ROT, FRACTION_BITS);
    localparam logic [K_W-1:0] K_EVEN  = qconst(PPB_EVEN, FRACTION_BITS);
    localparam logic [K_W-1:0] K_ODD   = qconst(PPB_ODD, FRACTION_BITS);

    logic [5:0] r_v;
    // stage 1
    t_word r_e10, r_e11, r_e13, r_d26, r_z13, r_z10, r_z11, r_z12;
    // stage 2
    t_word r2_e10, r2_e11, r2_e13, r2_z11, r2_z13, r_m26, r_m11, r_z5, r_me, r_mo;
    // stage 3
    t_word r3_e10, r3_e11, r3_e13, r3_m11, r_e12, r_o7, r_o10, r_o12;
    // stage 4
    t_word r_a0, r_a1, r_a2, r_a3, r_o6, r4_o7, r4_o10, r4_m11;
    // stage 5
    t_word r5_a2, r5_a3, r_o5, r_o4;
    t_word w_o5;

    // Advance valid through the six stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], i_start};
        end
    end

    assign o_done = r_v[5];
    assign w_o5   = r4_m11 - r_o6;

    // Input sums and differences
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_e10 <= i_x[0] + i_x[4];
            r_e11 <= i_x[0] - i_x[4];
            r_e13 <= i_x[2] + i_x[6];
            r_d26 <= i_x[2] - i_x[6];
            r_z13 <= i_x[5] + i_x[3];
            r_z10 <= i_x[5] - i_x[3];
            r_z11 <= i_x[1] + i_x[7];
            r_z12 <= i_x[1] - i_x[7];
        end
    end

    // Constant multiplications, each registered
    always_ff @(posedge i_clk) begin
        if (r_v[0]) begin
            r2_e10 <= r_e10;
            r2_e11 <= r_e11;
            r2_e13 <= r_e13;
            r2_z11 <= r_z11;
            r2_z13 <= r_z13;
            r_m26  <= mul_k(r_d26, K_SQRT2, FRACTION_BITS);
            r_m11  <= mul_k(r_z11 - r_z13, K_SQRT2, FRACTION_BITS);
            r_z5   <= mul_k(r_z10 + r_z12, K_ROT, FRACTION_BITS);
            r_me   <= mul_k(r_z12, K_EVEN, FRACTION_BITS);
            r_mo   <= mul_k(r_z10, K_ODD, FRACTION_BITS);
        end
    end

    // Rotation terms
    always_ff @(posedge i_clk) begin
        if (r_v[1]) begin
            r3_e10 <= r2_e10;
            r3_e11 <= r2_e11;
            r3_e13 <= r2_e13;
            r3_m11 <= r_m11;
            r_e12  <= r_m26 - r2_e13;
            r_o7   <= r2_z11 + r2_z13;
            r_o10  <= r_z5 - r_me;
            r_o12  <= r_z5 - r_mo;
        end
    end

    // Even half and first odd term
    always_ff @(posedge i_clk) begin
        if (r_v[2]) begin
            r_a0   <= r3_e10 + r3_e13;
            r_a3   <= r3_e10 - r3_e13;
            r_a1   <= r3_e11 + r_e12;
            r_a2   <= r3_e11 - r_e12;
            r_o6   <= r_o12 - r_o7;
            r4_o7  <= r_o7;
            r4_o10 <= r_o10;
            r4_m11 <= r3_m11;
        end
    end

    // Outer outputs and remaining odd terms, then inner outputs
    always_ff @(posedge i_clk) begin
        if (r_v[3]) begin
            o_y[0] <= r_a0 + r4_o7;
            o_y[7] <= r_a0 - r4_o7;
            o_y[1] <= r_a1 + r_o6;
            o_y[6] <= r_a1 - r_o6;
            r5_a2  <= r_a2;
            r5_a3  <= r_a3;
            r_o5   <= w_o5;
            r_o4   <= r4_o10 - w_o5;
        end
        if (r_v[4]) begin
            o_y[2] <= r5_a2 + r_o5;
            o_y[5] <= r5_a2 - r_o5;
            o_y[3] <= r5_a3 + r_o4;
            o_y[4] <= r5_a3 - r_o4;
        end
    end

endmodule

@@ hw/rtl/jidct_back.sv @@
module jidct_back #(
    parameter int FRACTION_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  jidct_pkg::t_tok                 i_tok,
    output logic                            o_tok_pop,
    output logic                            o_release,
    output logic                            o_coef_re,
    output logic [6:0]                      o_coef_raddr,
    input  logic [jidct_pkg::COEF_W-1:0]    i_coef_rdata,
    output logic                            o_tr_we,
    output logic [5:0]                      o_tr_waddr,
    output logic [jidct_pkg::TR_W-1:0]      o_tr_wdata,
    output logic                            o_tr_re,
    output logic [5:0]                      o_tr_raddr,
    input  logic [jidct_pkg::TR_W-1:0]      i_tr_rdata,
    output logic                            o_bf_start,
    output jidct_pkg::t_word                o_bf_x [8],
    input  logic                            i_bf_done,
    input  jidct_pkg::t_word                i_bf_y [8],
    output logic                            empty,
    input  logic                            pop,
    output logic [jidct_pkg::SAMPLE_W-1:0]  o_sample,
    output logic                            o_last_of_block
);
    import jidct_pkg::*;

    localparam t_scale_tab SCALE_TAB = build_scale(FRACTION_BITS);
    localparam t_word BIAS = t_word'(257) <<< (FRACTION_BITS - 1);
    localparam t_word SAT_HI = t_word'(64'sd2147483647);
    localparam t_word SAT_LO = -t_word'(64'sd2147483648);
    localparam int PROD_W = COEF_W + SCALE_W + 1;

    t_state r_state;
    t_state n_state;
    logic [3:0] r_k;
    logic [2:0] r_idx;
    logic       r_bank;
    logic       r_acz;
    t_word      r_x [8];
    logic       r_ov;

    logic [2:0]              w_row;
    logic signed [PROD_W-1:0] w_prod;
    t_word                   w_colv;
    t_word                   w_shift;
    logic                    w_free;
    logic                    w_push;

    assign w_row  = 3'(r_k - 4'd1);
    assign w_prod = $signed(i_coef_rdata) * $signed({1'b0, SCALE_TAB[{w_row, r_idx}]});
    assign w_colv = r_acz ? r_x[0] : i_bf_y[r_k[2:0]];
    assign w_shift = i_bf_y[r_k[2:0]] >>> FRACTION_BITS;
    assign w_free = !r_ov || pop;
    assign empty  = !r_ov;
    assign o_bf_x = r_x;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_tok.valid) n_state = ST_CLOAD;
            ST_CLOAD:  if (r_k == 4'd8) n_state = ST_CBF;
            ST_CBF:    if (i_bf_done) n_state = ST_CSTORE;
            ST_CSTORE: begin
                if (r_k[2:0] == 3'd7) n_state = (r_idx == 3'd7) ? ST_RLOAD : ST_CLOAD;
            end
            ST_RLOAD:  if (r_k == 4'd8) n_state = ST_RBF;
            ST_RBF:    if (i_bf_done) n_state = ST_ROUT;
            ST_ROUT: begin
                if (w_free && r_k[2:0] == 3'd7) begin
                    n_state = (r_idx == 3'd7) ? ST_IDLE : ST_RLOAD;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_tok_pop    = 1'b0;
        o_release    = 1'b0;
        o_coef_re    = 1'b0;
        o_coef_raddr = {r_bank, r_k[2:0], r_idx};
        o_tr_re      = 1'b0;
        o_tr_raddr   = {r_idx, r_k[2:0]};
        o_tr_we      = 1'b0;
        o_tr_waddr   = {r_k[2:0], r_idx};
        o_tr_wdata   = w_colv[TR_W-1:0];
        o_bf_start   = 1'b0;
        w_push       = 1'b0;
        if (w_colv > SAT_HI) begin
            o_tr_wdata = SAT_HI[TR_W-1:0];
        end else if (w_colv < SAT_LO) begin
            o_tr_wdata = SAT_LO[TR_W-1:0];
        end
        unique case (r_state)
            ST_IDLE:   o_tok_pop = i_tok.valid;
            ST_CLOAD:  o_coef_re = !r_k[3];
            ST_CBF:    o_bf_start = (r_k == 4'd0);
            ST_CSTORE: begin
                o_tr_we   = 1'b1;
                o_release = (r_k[2:0] == 3'd7) && (r_idx == 3'd7);
            end
            ST_RLOAD:  o_tr_re = !r_k[3];
            ST_RBF:    o_bf_start = (r_k == 4'd0);
            ST_ROUT:   w_push = w_free;
            default:   o_tok_pop = 1'b0;
        endcase
    end

    // Hold state, step counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state != n_state) begin
                r_k <= '0;
            end else if (r_state == ST_CLOAD || r_state == ST_RLOAD ||
                         r_state == ST_CSTORE || (r_state == ST_ROUT && w_free)) begin
                r_k <= r_k + 4'd1;
            end else if ((r_state == ST_CBF || r_state == ST_RBF) && r_k == 4'd0) begin
                r_k <= 4'd1;
            end
            if (r_state == ST_IDLE) begin
                r_idx <= '0;
            end else if ((r_state == ST_CSTORE && r_k[2:0] == 3'd7) ||
                         (r_state == ST_ROUT && w_free && r_k[2:0] == 3'd7)) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // Capture the bank, load operands, track zero AC terms
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_bank <= i_tok.bank;
        end
        if (r_state == ST_CLOAD) begin
            if (r_k == 4'd0) begin
                r_acz <= 1'b1;
            end else begin
                r_x[w_row] <= t_word'(w_prod);
                if (w_row != 3'd0 && i_coef_rdata != '0) begin
                    r_acz <= 1'b0;
                end
            end
        end
        if (r_state == ST_RLOAD && r_k != 4'd0) begin
            r_x[w_row] <= t_word'($signed(i_tr_rdata)) + ((w_row == 3'd0) ? BIAS : '0);
        end
    end

    // Output register, one result waiting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_push) begin
            r_ov <= 1'b1;
        end else if (pop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            if (w_shift < 0) begin
                o_sample <= '0;
            end else if (w_shift > t_word'(255)) begin
                o_sample <= 8'd255;
            end else begin
                o_sample <= w_shift[SAMPLE_W-1:0];
            end
            o_last_of_block <= (r_idx == 3'd7) && (r_k[2:0] == 3'd7);
        end
    end

endmodule

@@ hw/rtl/jidct_chk.sv @@
`include "jpeg_idct_8x8_aan_macros.svh"

module jidct_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_sample,
    input logic       o_last_of_block
);

    logic [5:0] r_in_cnt;
    logic [5:0] r_out_cnt;
    logic [2:0] r_blocks;
    logic       w_in_done;
    logic       w_out_done;

    assign w_in_done  = push && !full && (r_in_cnt == 6'd63);
    assign w_out_done = pop && !empty && (r_out_cnt == 6'd63);

    // Count transactions on both sides and blocks still owed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
            r_blocks  <= '0;
        end else begin
            if (push && !full) begin
                r_in_cnt <= r_in_cnt + 6'd1;
            end
            if (pop && !empty) begin
                r_out_cnt <= r_out_cnt + 6'd1;
            end
            if (w_in_done && !w_out_done) begin
                r_blocks <= r_blocks + 3'd1;
            end else if (!w_in_done && w_out_done) begin
                r_blocks <= r_blocks - 3'd1;
            end
        end
    end

    `JIDCT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_sample) && $stable(o_last_of_block), "result changed while stalled")
    `JIDCT_ASSERT_SAME(a_last, i_clk, i_rst_n, pop && !empty, o_last_of_block == (r_out_cnt == 6'd63), "end-of-block mark misplaced")
    `JIDCT_ASSERT_SAME(a_owed, i_clk, i_rst_n, !empty, r_blocks != 3'd0, "result without a complete block")

endmodule

bind jpeg_idct_8x8_aan jidct_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .push            (push),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_sample        (o_sample),
    .o_last_of_block (o_last_of_block)
);
